@@ design/tdh_pkg.sv @@
`default_nettype none
package tdh_pkg;

   typedef struct packed {
      logic        first_track;
      logic [15:0] flight_time;
      logic [19:0] path_length;
      logic [23:0] momentum;
   } req_type;

   typedef struct packed {
      logic signed [23:0] dt_electron;
      logic signed [23:0] dt_proton;
      logic signed [23:0] dt_pion;
      logic signed [23:0] dt_kaon;
      logic               zero_momentum;
   } rsp_type;

   // shared unit operating modes
   localparam logic [1:0] MODE_DIV  = 2'd0;
   localparam logic [1:0] MODE_SQRT = 2'd1;
   localparam logic [1:0] MODE_MUL  = 2'd2;

   localparam logic [5:0] DIV_STEPS  = 6'd49;
   localparam logic [5:0] SQRT_STEPS = 6'd32;

   // register indexes
   localparam logic [2:0] REG_ELECTRON = 3'd0;
   localparam logic [2:0] REG_PROTON   = 3'd1;
   localparam logic [2:0] REG_PION     = 3'd2;
   localparam logic [2:0] REG_KAON     = 3'd3;
   localparam logic [2:0] REG_SPEED    = 3'd4;

   typedef struct packed {
      logic        start;
      logic [1:0]  mode;
      logic [63:0] sh;
      logic [47:0] b;
   } iter_ctl_type;

   typedef struct packed {
      logic        done;
      logic [48:0] q;
      logic [61:0] acc;
      logic        ovf;
   } iter_res_type;

endpackage
`default_nettype wire

@@ design/tdh_iter_unit.sv @@
`default_nettype none
module tdh_iter_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tdh_pkg::iter_ctl_type ctl,
   output tdh_pkg::iter_res_type      res
);
   import tdh_pkg::*;

   localparam logic [61:0] MUL_LIMIT = 62'd1 << 57;

   logic        busy_ff;
   logic        done_ff;
   logic [1:0]  mode_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] sh_ff;
   logic [61:0] rem_ff;
   logic [48:0] q_ff;
   logic [47:0] b_ff;
   logic        ovf_ff;

   logic [61:0] a_op;
   logic [61:0] b_op;
   logic        sub;
   logic [62:0] sum;
   logic        last;

   always_comb begin
      unique case (mode_ff)
         MODE_DIV: begin
            a_op = {rem_ff[60:0], sh_ff[63]};
            b_op = {14'd0, b_ff};
            sub  = 1'b1;
         end
         MODE_SQRT: begin
            a_op = {rem_ff[59:0], sh_ff[63:62]};
            b_op = {11'd0, q_ff, 2'b01};
            sub  = 1'b1;
         end
         MODE_MUL: begin
            a_op = {rem_ff[60:0], 1'b0};
            b_op = sh_ff[63] ? {14'd0, b_ff} : 62'd0;
            sub  = 1'b0;
         end
         default: begin
            a_op = 62'd0;
            b_op = 62'd0;
            sub  = 1'b0;
         end
      endcase
      // carry out on subtract means a_op >= b_op
      sum  = {1'b0, a_op} + {1'b0, (sub ? ~b_op : b_op)} + {62'd0, sub};
      last = cnt_ff == ((mode_ff == MODE_SQRT) ? SQRT_STEPS - 6'd1 : DIV_STEPS - 6'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last && !ctl.start;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mode_ff <= ctl.mode;
         sh_ff   <= ctl.sh;
         b_ff    <= ctl.b;
         rem_ff  <= 62'd0;
         q_ff    <= 49'd0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= 6'd0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         sh_ff  <= (mode_ff == MODE_SQRT) ? {sh_ff[61:0], 2'b00} : {sh_ff[62:0], 1'b0};
         if (mode_ff == MODE_MUL) begin
            // accumulator only grows, so an overflow stays an overflow
            if (!ovf_ff) begin
               rem_ff <= sum[61:0];
               if (sum[61:0] > MUL_LIMIT) begin
                  ovf_ff <= 1'b1;
               end
            end
         end else if (sum[62]) begin
            rem_ff <= sum[61:0];
            q_ff   <= {q_ff[47:0], 1'b1};
         end else begin
            rem_ff <= a_op;
            q_ff   <= {q_ff[47:0], 1'b0};
         end
      end
   end

   assign res.done = done_ff;
   assign res.q    = q_ff;
   assign res.acc  = rem_ff;
   assign res.ovf  = ovf_ff;

endmodule
`default_nettype wire

@@ design/tof_delta_t_hypotheses_unit.sv @@
`default_nettype none
// the sequencer holds off a new request until the previous result has reached the output register;
// the bit-serial divide/sqrt/multiply unit does one path divide, then a sqrt, a divide and a
// multiply for each mass hypothesis; zero momentum skips the mass hypotheses
// a finished result waits in the output register while the next request is taken
// reset is synchronous: registers return to their defaults, reference vertex to zero
module tof_delta_t_hypotheses_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tdh_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tdh_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import tdh_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PATH  = 4'd1;
   localparam logic [3:0] S_VERT  = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_GDIV  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_ACCUM = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   localparam logic signed [41:0] VERT_MIN = -(42'sd1 <<< 24);
   localparam logic signed [41:0] VERT_MAX = (42'sd1 <<< 24) - 42'sd1;
   localparam logic signed [27:0] DT_MIN   = -(28'sd1 <<< 23);
   localparam logic signed [27:0] DT_MAX   = (28'sd1 <<< 23) - 28'sd1;
   localparam logic [29:0]        D_LIMIT  = 30'd1 << 25;

   logic [3:0]         state_ff;
   logic [1:0]         k_ff;
   logic               first_ff;
   logic [15:0]        t_ff;
   logic [23:0]        p_ff;
   logic [47:0]        psq_ff;
   logic [47:0]        pq_ff;
   logic signed [24:0] vertex_ff;
   logic signed [23:0] dt_ff [4];
   logic               zero_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [20:0]        electron_ff;
   logic [20:0]        proton_ff;
   logic [20:0]        pion_ff;
   logic [20:0]        kaon_ff;
   logic [21:0]        speed_ff;

   iter_ctl_type ctl;
   iter_res_type res;

   logic               accept;
   logic               rsp_free;
   logic               csr_write;
   logic [1:0]         idx;
   logic [20:0]        mass_sel;
   logic [41:0]        msq;
   logic [48:0]        radicand;
   logic [21:0]        speed_nz;
   logic [40:0]        path_rnd;
   logic signed [41:0] vert_full;
   logic signed [24:0] vert_in;
   logic [61:0]        prod_rnd;
   logic [29:0]        d_val;
   logic signed [27:0] dt_full;
   logic signed [23:0] dt_in;

   tdh_iter_unit u_iter (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .res   (res)
   );

   assign req_stall  = state_ff != S_IDLE;
   assign accept     = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      idx = (state_ff == S_VERT) ? 2'd0 : k_ff + 2'd1;
      unique case (idx)
         2'd0:    mass_sel = electron_ff;
         2'd1:    mass_sel = proton_ff;
         2'd2:    mass_sel = pion_ff;
         default: mass_sel = kaon_ff;
      endcase
      msq      = mass_sel * mass_sel;
      radicand = {1'b0, psq_ff} + {7'd0, msq};
      speed_nz = (speed_ff == 22'd0) ? 22'd1 : speed_ff;

      // vertex time, beta taken as one
      path_rnd  = 41'(({1'b0, pq_ff} + 49'd128) >> 8);
      vert_full = $signed({26'd0, t_ff}) - $signed({1'b0, path_rnd});
      if (vert_full < VERT_MIN) begin
         vert_in = 25'(VERT_MIN);
      end else if (vert_full > VERT_MAX) begin
         vert_in = 25'(VERT_MAX);
      end else begin
         vert_in = 25'(vert_full);
      end

      prod_rnd = res.acc + (62'd1 << 31);
      if (res.ovf || (prod_rnd[61:32] > D_LIMIT)) begin
         d_val = D_LIMIT;
      end else begin
         d_val = prod_rnd[61:32];
      end
      dt_full = 28'(vertex_ff) - $signed({12'd0, t_ff}) + $signed({2'd0, 26'(d_val)});
      if (dt_full < DT_MIN) begin
         dt_in = 24'(DT_MIN);
      end else if (dt_full > DT_MAX) begin
         dt_in = 24'(DT_MAX);
      end else begin
         dt_in = 24'(dt_full);
      end
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.start = 1'b1;
               ctl.mode  = MODE_DIV;
               ctl.sh    = {1'b0, req_payload.path_length, 28'd0, 15'd0};
               ctl.b     = {26'd0, speed_nz};
            end
         end
         S_VERT: begin
            if (p_ff != 24'd0) begin
               ctl.start = 1'b1;
               ctl.mode  = MODE_SQRT;
               ctl.sh    = {1'b0, radicand, 14'd0};
            end
         end
         S_SQRT: begin
            if (res.done) begin
               ctl.start = 1'b1;
               ctl.mode  = MODE_DIV;
               ctl.sh    = {res.q[31:0], 17'd0, 15'd0};
               ctl.b     = {24'd0, p_ff};
            end
         end
         S_GDIV: begin
            if (res.done) begin
               ctl.start = 1'b1;
               ctl.mode  = MODE_MUL;
               ctl.sh    = {res.q, 15'd0};
               ctl.b     = pq_ff;
            end
         end
         S_ACCUM: begin
            if (k_ff != 2'd3) begin
               ctl.start = 1'b1;
               ctl.mode  = MODE_SQRT;
               ctl.sh    = {1'b0, radicand, 14'd0};
            end
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vertex_ff    <= 25'sd0;
         electron_ff  <= 21'd511;
         proton_ff    <= 21'd938272;
         pion_ff      <= 21'd139570;
         kaon_ff      <= 21'd493677;
         speed_ff     <= 22'd1964722;
         k_ff         <= 2'd0;
      end else begin
         if (csr_write) begin
            unique case (csr_paddr[4:2])
               REG_ELECTRON: electron_ff <= csr_pwdata[20:0];
               REG_PROTON:   proton_ff   <= csr_pwdata[20:0];
               REG_PION:     pion_ff     <= csr_pwdata[20:0];
               REG_KAON:     kaon_ff     <= csr_pwdata[20:0];
               REG_SPEED:    speed_ff    <= csr_pwdata[21:0];
               default:      ;
            endcase
         end

         if (state_ff == S_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_PATH;
               end
            end
            S_PATH: begin
               if (res.done) begin
                  state_ff <= S_VERT;
               end
            end
            S_VERT: begin
               if (first_ff) begin
                  vertex_ff <= vert_in;
               end
               k_ff     <= 2'd0;
               state_ff <= (p_ff == 24'd0) ? S_OUT : S_SQRT;
            end
            S_SQRT: begin
               if (res.done) begin
                  state_ff <= S_GDIV;
               end
            end
            S_GDIV: begin
               if (res.done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (res.done) begin
                  state_ff <= S_ACCUM;
               end
            end
            S_ACCUM: begin
               if (k_ff == 2'd3) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_SQRT;
               end
            end
            S_OUT: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= req_payload.first_track;
         t_ff     <= req_payload.flight_time;
         p_ff     <= req_payload.momentum;
         psq_ff   <= req_payload.momentum * req_payload.momentum;
      end
      if (state_ff == S_PATH && res.done) begin
         pq_ff <= res.q[47:0];
      end
      if (state_ff == S_VERT) begin
         zero_ff <= p_ff == 24'd0;
         if (p_ff == 24'd0) begin
            dt_ff[0] <= 24'sd0;
            dt_ff[1] <= 24'sd0;
            dt_ff[2] <= 24'sd0;
            dt_ff[3] <= 24'sd0;
         end
      end
      if (state_ff == S_ACCUM) begin
         dt_ff[k_ff] <= dt_in;
      end
      if (state_ff == S_OUT && rsp_free) begin
         rsp_ff.dt_electron   <= dt_ff[0];
         rsp_ff.dt_proton     <= dt_ff[1];
         rsp_ff.dt_pion       <= dt_ff[2];
         rsp_ff.dt_kaon       <= dt_ff[3];
         rsp_ff.zero_momentum <= zero_ff;
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ELECTRON: csr_prdata = {11'd0, electron_ff};
         REG_PROTON:   csr_prdata = {11'd0, proton_ff};
         REG_PION:     csr_prdata = {11'd0, pion_ff};
         REG_KAON:     csr_prdata = {11'd0, kaon_ff};
         REG_SPEED:    csr_prdata = {10'd0, speed_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_unit_idle_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !res.done)
      else $error("shared unit finished while sequencer idle");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> !ctl.start)
      else $error("shared unit restarted back to back");

   a_zero_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_momentum |-> rsp_payload.dt_electron == 24'sd0
         && rsp_payload.dt_kaon == 24'sd0)
      else $error("zero momentum result carries nonzero delta");

   a_result_after_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output state");
`endif

endmodule
`default_nettype wire

@@ tb/tof_delta_t_hypotheses_checker.sv @@
`timescale 1ns / 100ps
module tof_delta_t_hypotheses_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire tdh_pkg::req_type req_payload,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire tdh_pkg::rsp_type rsp_payload,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic             csr_pready,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output int                    fail_count,
   output int                    pending_dt
);
   import tdh_pkg::*;

   localparam longint unsigned D_CAP    = 64'd1 << 25;
   localparam longint unsigned PROD_CAP = 64'd1 << 57;

   logic [20:0] mass_hyp [4];
   logic [21:0] speed_q16;
   longint      evt_vertex;
   rsp_type     dt_queue [$];

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // flight time under one mass, 2^-8 ns, capped at 2^25
   function automatic longint unsigned flight_under_mass(input longint unsigned pq,
         input longint unsigned p, input longint unsigned m);
      longint unsigned e, g, d;
      if (pq == 0) return 0;
      e = int_sqrt((p * p + m * m) << 14);
      g = (e << 17) / p;
      if (g > PROD_CAP / pq) return D_CAP;
      d = (pq * g + (64'd1 << 31)) >> 32;
      return (d > D_CAP) ? D_CAP : d;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict_track(input req_type trk);
      longint unsigned c, pq;
      longint          dt;
      rsp_type         res;
      c = (speed_q16 == 0) ? 1 : speed_q16;
      pq = (longint'(trk.path_length) << 28) / c;
      if (trk.first_track)
         evt_vertex = clamp(longint'(trk.flight_time) - longint'((pq + 128) >> 8),
                            -(64'sd1 << 24), (64'sd1 << 24) - 1);
      res = '0;
      if (trk.momentum == 0) begin
         res.zero_momentum = 1'b1;
      end else begin
         for (int k = 0; k < 4; k++) begin
            dt = evt_vertex - longint'(trk.flight_time)
                 + longint'(flight_under_mass(pq, trk.momentum, mass_hyp[2'(k)]));
            dt = clamp(dt, -(64'sd1 << 23), (64'sd1 << 23) - 1);
            case (k)
               0: res.dt_electron = dt[23:0];
               1: res.dt_proton   = dt[23:0];
               2: res.dt_pion     = dt[23:0];
               default: res.dt_kaon = dt[23:0];
            endcase
         end
      end
      dt_queue.push_back(res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mass_hyp[REG_ELECTRON[1:0]] <= 21'd511;
         mass_hyp[REG_PROTON[1:0]]   <= 21'd938272;
         mass_hyp[REG_PION[1:0]]     <= 21'd139570;
         mass_hyp[REG_KAON[1:0]]     <= 21'd493677;
         speed_q16   <= 22'd1964722;
         evt_vertex = 0;
         dt_queue.delete();
         fail_count <= 0;
         pending_dt <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2]) inside
               REG_ELECTRON, REG_PROTON, REG_PION, REG_KAON:
                  mass_hyp[csr_paddr[3:2]] <= csr_pwdata[20:0];
               REG_SPEED: speed_q16 <= csr_pwdata[21:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_track(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (dt_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               rsp_type want;
               want = dt_queue.pop_front();
               if (want !== rsp_payload) begin
                  $display("%0t: mismatch expected e=%0d p=%0d pi=%0d k=%0d z=%0b",
                           $time, want.dt_electron, want.dt_proton, want.dt_pion,
                           want.dt_kaon, want.zero_momentum);
                  $display("%0t:          actual e=%0d p=%0d pi=%0d k=%0d z=%0b",
                           $time, rsp_payload.dt_electron, rsp_payload.dt_proton,
                           rsp_payload.dt_pion, rsp_payload.dt_kaon,
                           rsp_payload.zero_momentum);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_dt <= dt_queue.size();
      end
   end
endmodule

@@ tb/tof_delta_t_hypotheses_unit_tb.sv @@
`timescale 1ns / 100ps
module tof_delta_t_hypotheses_unit_tb;
   import tdh_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_payload;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending_dt;
   int          cycle_count = 0;
   int          burst_left = 0;

   tof_delta_t_hypotheses_unit uut (.*);

   tof_delta_t_hypotheses_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall pattern: quiet, random, long stretches
   int stall_mode = 0, stall_left = 0;
   always @(posedge clock) begin
      if (cycle_count % 3000 == 0) stall_mode <= $urandom_range(0, 2);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_mode == 1) begin
         rsp_stall <= 1'($urandom_range(0, 1));
      end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 40);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_track(input req_type trk);
      req_payload <= trk;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 0;
         repeat ($urandom_range(0, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 6);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      // let the count of the last accepted request settle first
      @(posedge clock);
      while (pending_dt != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type mk(input logic f, input logic [15:0] t, input logic [19:0] r,
                                  input logic [23:0] p);
      req_type x;
      x.first_track = f; x.flight_time = t; x.path_length = r; x.momentum = p;
      return x;
   endfunction

   function automatic req_type random_track();
      req_type x;
      x.first_track = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
         7: begin
            x.flight_time = 16'($urandom); x.path_length = 20'($urandom);
            x.momentum = 24'($urandom);
         end
         8: begin
            x.flight_time = 16'($urandom); x.path_length = 20'($urandom_range(0, 20000));
            x.momentum = 0;
         end
         9: begin
            x.flight_time = $urandom_range(0, 1) ? 16'hffff : 16'h0;
            x.path_length = $urandom_range(0, 1) ? 20'hfffff : 20'($urandom_range(0, 3));
            x.momentum = $urandom_range(0, 1) ? 24'hffffff : 24'($urandom_range(1, 4));
         end
         default: begin
            // tracks of a plausible event
            x.path_length = 20'($urandom_range(4000, 12000));
            x.flight_time = 16'($urandom_range(2000, 12000));
            x.momentum = 24'($urandom_range(50000, 4000000));
         end
      endcase
      return x;
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) send_track(random_track());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // directed tracks on default registers
      send_track(mk(1, 16'd5000, 20'd8000, 24'd0));
      send_track(mk(0, 16'd5200, 20'd8000, 24'd500000));
      send_track(mk(0, 16'd5200, 20'd8000, 24'd1));
      send_track(mk(0, 16'hffff, 20'hfffff, 24'hffffff));
      send_track(mk(0, 16'h0, 20'h0, 24'hffffff));
      send_track(mk(1, 16'hffff, 20'h0, 24'd1000000));
      send_track(mk(1, 16'h0, 20'hfffff, 24'd1000000));
      send_track(mk(0, 16'h0, 20'hfffff, 24'd1));
      send_track(mk(1, 16'd3000, 20'd6000, 24'd200000));
      send_track(mk(0, 16'd3100, 20'd6100, 24'd0));
      send_track(mk(0, 16'd3100, 20'd6100, 24'd2000000));
      drain();

      // massless hypotheses give beta of one; fastest light speed
      for (int k = REG_ELECTRON; k <= REG_KAON; k++) csr_write(3'(k), 32'd0);
      csr_write(REG_SPEED, 32'd4194303);
      send_track(mk(1, 16'd4000, 20'd9000, 24'd300000));
      send_track(mk(0, 16'd4100, 20'd9000, 24'd1));
      send_track(mk(0, 16'hffff, 20'hfffff, 24'hffffff));
      drain();
      random_phase(300);

      // heaviest masses, slowest light speed
      for (int k = REG_ELECTRON; k <= REG_KAON; k++) csr_write(3'(k), 32'd2097151);
      csr_write(REG_SPEED, 32'd1);
      send_track(mk(1, 16'd10, 20'd1, 24'd1));
      send_track(mk(0, 16'd10, 20'd1, 24'hffffff));
      random_phase(300);

      // light speed of zero, upper data bits set, unmapped addresses
      for (int k = REG_ELECTRON; k <= REG_KAON; k++)
         csr_write(3'(k), {11'($urandom), 21'($urandom)});
      csr_write(REG_SPEED, 32'hffc00000);
      csr_write(3'd5, $urandom);
      csr_write(3'd7, $urandom);
      random_phase(300);

      // back to the physical values with a random light speed
      csr_write(REG_ELECTRON, 32'd511);
      csr_write(REG_PROTON, 32'd938272);
      csr_write(REG_PION, 32'd139570);
      csr_write(REG_KAON, 32'd493677);
      csr_write(REG_SPEED, $urandom_range(1500000, 2500000));
      random_phase(350);

      for (int k = REG_ELECTRON; k <= REG_KAON; k++) csr_write(3'(k), $urandom);
      csr_write(REG_SPEED, $urandom);
      random_phase(380);

      drain();
      repeat (600) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
